FILE: design/tpc_pkg.sv
package tpc_pkg;

  localparam int ID_COUNT_DEF  = 1024;
  localparam int AGE_BITS_DEF  = 8;

  localparam int TAG_ID_W      = 10;
  localparam int CORNER_W      = 16;
  localparam int CORNERS_W     = 8 * CORNER_W;
  localparam int PERSIST_W     = 8;
  localparam int AGE_OUT_W     = 8;
  // width that ages are extended to, used for compares against persistence
  localparam int AGE_EXT_W     = 16;

  localparam logic [PERSIST_W-1:0] PERSIST_RST = 8'd5;
  localparam logic [AGE_OUT_W-1:0] AGE_OUT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_DETECT = 2'd0,
    KIND_EOF    = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef struct packed {
    logic capture;     // latch the accepted beat
    logic det_write;   // store a detection
    logic lookup;      // read both stores at the beat's id
    logic cnt_clear;   // restart the entry counter
    logic clear_step;  // clearing pass: zero one status entry
    logic sweep_step;  // end of frame: one read-modify-write step
    logic load_out;    // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_done;    // counter has passed the last entry
    logic wb_pend;     // sweep write-back still in flight
    logic out_free;    // output register can take a result
  } dp_sts_t;

endpackage

FILE: design/tag_persistence_cache.sv
// Tag persistence cache: holds the last-seen corners of tags, one entry per id.
// Input channel (in_valid_i / in_stall_o) carries one beat per item: kind,
// tag id and four corners. kind detection stores the corners and ages the
// entry to zero; end of frame sweeps all entries (seen entries drop their
// mark, unseen ones age by one or are evicted past the persistence limit);
// read returns presence, age and held corners for an id.
// Output channel (out_valid_o / out_stall_i) carries exactly one beat per item.
// Config: cfg_we_i writes cfg_wdata_i into persistence (reset value 5); write
// only while the block is idle.
// Timing: a detection, read or unused kind is captured on accept; its
// result is loaded into the output register from the result state, and
// only then is the next beat taken. An end of frame walks the status memory
// one entry per cycle, each read followed by its write-back, then loads its
// result the same way. The output register decouples the sides: a new beat is
// taken while a result waits; a result only stalls the block when the next
// result is ready and the old one is still held.
// Reset: a clearing pass zeros the status memory, with in_stall_o high while
// it runs. Corner memory is never cleared and only shown for held ids.
module tag_persistence_cache #(
  parameter int ID_COUNT = tpc_pkg::ID_COUNT_DEF,
  parameter int AGE_BITS = tpc_pkg::AGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [tpc_pkg::TAG_ID_W-1:0]   tag_id_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner0_x_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner0_y_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner1_x_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner1_y_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner2_x_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner2_y_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner3_x_i,
  input  logic [tpc_pkg::CORNER_W-1:0]   corner3_y_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           present_o,
  output logic [tpc_pkg::AGE_OUT_W-1:0]  frames_unseen_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held0_x_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held0_y_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held1_x_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held1_y_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held2_x_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held2_y_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held3_x_o,
  output logic [tpc_pkg::CORNER_W-1:0]   held3_y_o,

  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::PERSIST_W-1:0]  cfg_wdata_i
);
  import tpc_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [CORNERS_W-1:0] corners;
  logic [CORNERS_W-1:0] held;

  // corner 0 x in the top bits, corner 3 y in the bottom bits
  assign corners = {corner0_x_i, corner0_y_i, corner1_x_i, corner1_y_i,
                    corner2_x_i, corner2_y_i, corner3_x_i, corner3_y_i};

  tpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpc_dp #(
    .ID_COUNT (ID_COUNT),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .tag_id_i        (tag_id_i),
    .corners_i       (corners),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .present_o       (present_o),
    .frames_unseen_o (frames_unseen_o),
    .held_o          (held)
  );

  assign held0_x_o = held[8*CORNER_W-1:7*CORNER_W];
  assign held0_y_o = held[7*CORNER_W-1:6*CORNER_W];
  assign held1_x_o = held[6*CORNER_W-1:5*CORNER_W];
  assign held1_y_o = held[5*CORNER_W-1:4*CORNER_W];
  assign held2_x_o = held[4*CORNER_W-1:3*CORNER_W];
  assign held2_y_o = held[3*CORNER_W-1:2*CORNER_W];
  assign held3_x_o = held[2*CORNER_W-1:CORNER_W];
  assign held3_y_o = held[CORNER_W-1:0];

endmodule

FILE: design/tpc_ram.sv
module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tpc_ctrl.sv
module tpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  tpc_pkg::dp_sts_t sts_i,
  output tpc_pkg::dp_cmd_t cmd_o
);
  import tpc_pkg::*;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.cnt_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (kind_i)
            KIND_DETECT: begin
              cmd_o.det_write = 1'b1;
              state_d         = S_RESULT;
            end
            KIND_READ: begin
              cmd_o.lookup = 1'b1;
              state_d      = S_RESULT;
            end
            KIND_EOF: begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = S_SWEEP;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.cnt_done && !sts_i.wb_pend) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // one beat at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("beat accepted while previous one in flight");

  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) && sts_i.cnt_done && !sts_i.wb_pend |=> state_q == S_RESULT)
    else $error("sweep did not finish");

  a_load_only_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> !cmd_o.load_out)
    else $error("two results loaded for one beat");

endmodule

FILE: design/tpc_dp.sv
module tpc_dp #(
  parameter int ID_COUNT = tpc_pkg::ID_COUNT_DEF,
  parameter int AGE_BITS = tpc_pkg::AGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tpc_pkg::dp_cmd_t               cmd_i,
  output tpc_pkg::dp_sts_t               sts_o,
  input  logic [1:0]                     kind_i,
  input  logic [tpc_pkg::TAG_ID_W-1:0]   tag_id_i,
  input  logic [tpc_pkg::CORNERS_W-1:0]  corners_i,
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::PERSIST_W-1:0]  cfg_wdata_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           present_o,
  output logic [tpc_pkg::AGE_OUT_W-1:0]  frames_unseen_o,
  output logic [tpc_pkg::CORNERS_W-1:0]  held_o
);
  import tpc_pkg::*;

  localparam int ID_W  = $clog2(ID_COUNT);
  localparam int CNT_W = $clog2(ID_COUNT + 1);
  localparam int ST_W  = AGE_BITS + 2;  // {valid, seen, age}
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [PERSIST_W-1:0] persist_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q;
  logic [ID_W-1:0]      wb_addr_q;

  logic [1:0]           kind_q;
  logic                 id_ok_q;
  logic [CORNERS_W-1:0] corners_q;

  logic                 out_valid_q;
  logic                 present_q;
  logic [AGE_OUT_W-1:0] age_out_q;
  logic [CORNERS_W-1:0] held_q;

  logic                 id_ok, cnt_done;
  logic [ID_W-1:0]      id_addr, cnt_addr;
  logic                 clr_we, wb_we, det_we, sw_re;

  logic                 st_we, st_re;
  logic [ID_W-1:0]      st_waddr, st_raddr;
  logic [ST_W-1:0]      st_wdata, st_rdata, wb_data;
  logic [CORNERS_W-1:0] cn_rdata;

  logic                 st_valid, st_seen;
  logic [AGE_BITS-1:0]  st_age;
  logic [AGE_EXT_W-1:0] st_age_ext;

  logic                 present_d;
  logic [AGE_OUT_W-1:0] age_out_d;
  logic [CORNERS_W-1:0] held_d;

  assign id_ok    = 32'(tag_id_i) < 32'(ID_COUNT);
  assign id_addr  = ID_W'(tag_id_i);
  assign cnt_done = cnt_q == CNT_W'(ID_COUNT);
  assign cnt_addr = cnt_q[ID_W-1:0];

  assign clr_we = cmd_i.clear_step && !cnt_done;
  assign sw_re  = cmd_i.sweep_step && !cnt_done;
  assign wb_we  = pend_q;
  assign det_we = cmd_i.det_write && id_ok;

  assign st_valid   = st_rdata[ST_W-1];
  assign st_seen    = st_rdata[ST_W-2];
  assign st_age     = st_rdata[AGE_BITS-1:0];
  assign st_age_ext = AGE_EXT_W'(st_age);

  // sweep update of one entry
  always_comb begin
    wb_data = st_rdata;
    if (st_valid) begin
      if (st_seen) begin
        wb_data[ST_W-2] = 1'b0;
      end else if (st_age_ext > AGE_EXT_W'(persist_q)) begin
        wb_data = '0;
      end else if (st_age != AGE_MAX) begin
        wb_data[AGE_BITS-1:0] = st_age + 1'b1;
      end
    end
  end

  always_comb begin
    st_we    = clr_we || wb_we || det_we;
    st_waddr = id_addr;
    st_wdata = {1'b1, 1'b1, {AGE_BITS{1'b0}}};
    if (clr_we) begin
      st_waddr = cnt_addr;
      st_wdata = '0;
    end else if (wb_we) begin
      st_waddr = wb_addr_q;
      st_wdata = wb_data;
    end
  end

  assign st_re    = cmd_i.lookup || sw_re;
  assign st_raddr = sw_re ? cnt_addr : id_addr;

  tpc_ram #(
    .WIDTH (ST_W),
    .DEPTH (ID_COUNT)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tpc_ram #(
    .WIDTH (CORNERS_W),
    .DEPTH (ID_COUNT)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (det_we),
    .waddr_i (id_addr),
    .wdata_i (corners_i),
    .re_i    (cmd_i.lookup),
    .raddr_i (id_addr),
    .rdata_o (cn_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (clr_we || sw_re) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // result of the captured beat
  always_comb begin
    present_d = 1'b0;
    age_out_d = '0;
    held_d    = '0;
    case (kind_q)
      KIND_DETECT: begin
        if (id_ok_q) begin
          present_d = 1'b1;
          held_d    = corners_q;
        end
      end
      KIND_READ: begin
        if (id_ok_q && st_valid) begin
          present_d = 1'b1;
          age_out_d = (st_age_ext > AGE_EXT_W'(AGE_OUT_MAX)) ? AGE_OUT_MAX
                                                             : st_age_ext[AGE_OUT_W-1:0];
          held_d    = cn_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persist_q   <= PERSIST_RST;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        persist_q <= cfg_wdata_i;
      end
      cnt_q  <= cnt_d;
      pend_q <= sw_re;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_re) begin
      wb_addr_q <= cnt_addr;
    end
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      id_ok_q   <= id_ok;
      corners_q <= corners_i;
    end
    if (cmd_i.load_out) begin
      present_q <= present_d;
      age_out_q <= age_out_d;
      held_q    <= held_d;
    end
  end

  assign sts_o.cnt_done = cnt_done;
  assign sts_o.wb_pend  = pend_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign present_o       = present_q;
  assign frames_unseen_o = age_out_q;
  assign held_o          = held_q;

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({clr_we, wb_we, det_we}) <= 1)
    else $error("status store write collision");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ID_COUNT))
    else $error("entry counter out of range");

  a_wb_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(sw_re))
    else $error("write-back without a sweep read");

endmodule
